// ===== hw/rtl/mrcc_pkg.sv =====
// ----------------------------------------------------------------------------
// mrcc_pkg
// Shared types and constants of the MESI requester cache controller.
// ----------------------------------------------------------------------------
package mrcc_pkg;

  // geometry
  localparam int unsigned LINES      = 16;
  localparam int unsigned MEM_WORDS  = 256;
  localparam int unsigned ADDR_W     = 8;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned LINE_IDX_W = $clog2(LINES);
  localparam int unsigned MEM_IDX_W  = $clog2(MEM_WORDS);

  // MESI line states
  typedef enum logic [1:0] {
    ST_MODIFIED  = 2'd0,
    ST_EXCLUSIVE = 2'd1,
    ST_SHARED    = 2'd2,
    ST_INVALID   = 2'd3
  } line_state_e;

  // bus broadcast commands
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } bus_cmd_e;

  // backing memory read request
  typedef struct packed {
    logic                 en;
    logic [MEM_IDX_W-1:0] addr;
  } mem_rd_t;

  // backing memory write request
  typedef struct packed {
    logic                 en;
    logic [MEM_IDX_W-1:0] addr;
    logic [DATA_W-1:0]    data;
  } mem_wr_t;

endpackage

// ===== hw/rtl/mrcc_if.sv =====
// ----------------------------------------------------------------------------
// mrcc_if
// Valid/ready channels for core requests and controller results.
// ----------------------------------------------------------------------------
interface mrcc_req_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic        [mrcc_pkg::ADDR_W-1:0] address;
  logic signed [mrcc_pkg::DATA_W-1:0] write_value;
  logic                                shared_hit;
  logic signed [mrcc_pkg::DATA_W-1:0] shared_value;

  modport source (
    output valid, req_type, address, write_value, shared_hit, shared_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, address, write_value, shared_hit, shared_value,
    output ready
  );
endinterface

interface mrcc_rsp_if;
  logic                                valid;
  logic                                ready;
  logic        [1:0]                   bus_cmd;
  logic        [mrcc_pkg::ADDR_W-1:0] bus_address;
  logic signed [mrcc_pkg::DATA_W-1:0] bcast_data;
  logic signed [mrcc_pkg::DATA_W-1:0] line_data;
  logic        [1:0]                   line_state;
  logic                                wrote_back;

  modport source (
    output valid, bus_cmd, bus_address, bcast_data, line_data, line_state, wrote_back,
    input  ready
  );
  modport sink (
    input  valid, bus_cmd, bus_address, bcast_data, line_data, line_state, wrote_back,
    output ready
  );
endinterface

// ===== hw/rtl/mrcc_backing_mem.sv =====
// ----------------------------------------------------------------------------
// mrcc_backing_mem
// Backing memory with per-word valid bits (unwritten words read as zero)
// and write-to-read forwarding for a read launched at the write edge.
// ----------------------------------------------------------------------------
module mrcc_backing_mem (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mrcc_pkg::mem_rd_t               rd_i,
  input  mrcc_pkg::mem_wr_t               wr_i,
  output logic [mrcc_pkg::DATA_W-1:0]     fill_o
);

  logic [mrcc_pkg::DATA_W-1:0]    mem_q [mrcc_pkg::MEM_WORDS];
  logic [mrcc_pkg::MEM_WORDS-1:0] vld_q;
  logic [mrcc_pkg::DATA_W-1:0]    rd_data_q;
  logic                           rd_vld_q;
  logic                           fwd_q;
  logic [mrcc_pkg::DATA_W-1:0]    fwd_data_q;

  // storage array, registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_data_q  <= mem_q[rd_i.addr];
      fwd_data_q <= wr_i.data;
    end
  end

  // word valid bits and read-side control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        rd_vld_q <= vld_q[rd_i.addr];
        fwd_q    <= wr_i.en && (wr_i.addr == rd_i.addr);
      end
    end
  end

  // fill byte: forwarded write, stored word, or zero for a never-written word
  always_comb begin
    if (fwd_q) begin
      fill_o = fwd_data_q;
    end else if (rd_vld_q) begin
      fill_o = rd_data_q;
    end else begin
      fill_o = '0;
    end
  end

endmodule

// ===== hw/rtl/mesi_requester_cache_controller_core.sv =====
// ----------------------------------------------------------------------------
// mesi_requester_cache_controller_core
// Direct-mapped write-back cache with MESI line states, requester side.
// ----------------------------------------------------------------------------
// order: a request passes the request register, then the result register, which
//   a stalled result side holds; the backing memory read is launched at accept
// throughput: one request per cycle while the result side keeps up
// reset: all lines Invalid, backing memory reads as zero through per-word
//   valid bits, so no clearing pass is needed and requests are taken at once
module mesi_requester_cache_controller_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  mrcc_req_if.sink   req_i,
  mrcc_rsp_if.source rsp_o
);

  // request register
  logic                            s1_valid_q;
  logic                            s1_write_q;
  logic [mrcc_pkg::ADDR_W-1:0]     s1_addr_q;
  logic [mrcc_pkg::DATA_W-1:0]     s1_wval_q;
  logic                            s1_shit_q;
  logic [mrcc_pkg::DATA_W-1:0]     s1_sval_q;

  // line arrays
  mrcc_pkg::line_state_e           states_q [mrcc_pkg::LINES];
  logic [mrcc_pkg::ADDR_W-1:0]     tags_q   [mrcc_pkg::LINES];
  logic [mrcc_pkg::DATA_W-1:0]     values_q [mrcc_pkg::LINES];

  // result register
  logic                            out_valid_q;
  mrcc_pkg::bus_cmd_e              out_cmd_q;
  logic [mrcc_pkg::ADDR_W-1:0]     out_baddr_q;
  logic [mrcc_pkg::DATA_W-1:0]     out_bdata_q;
  logic [mrcc_pkg::DATA_W-1:0]     out_ldata_q;
  mrcc_pkg::line_state_e           out_lstate_q;
  logic                            out_wb_q;

  logic                            s1_adv;
  logic                            accept;
  logic [mrcc_pkg::LINE_IDX_W-1:0] idx;
  mrcc_pkg::line_state_e           cur_st;
  logic [mrcc_pkg::ADDR_W-1:0]     cur_tag;
  logic [mrcc_pkg::DATA_W-1:0]     cur_val;
  logic                            holds;
  logic                            evict_dirty;
  logic [mrcc_pkg::DATA_W-1:0]     fill;
  mrcc_pkg::bus_cmd_e              cmd_d;
  logic [mrcc_pkg::ADDR_W-1:0]     baddr_d;
  logic [mrcc_pkg::DATA_W-1:0]     bdata_d;
  logic [mrcc_pkg::DATA_W-1:0]     val_d;
  mrcc_pkg::line_state_e           st_d;
  logic                            wb_d;
  logic                            upd_d;
  mrcc_pkg::mem_rd_t               mem_rd;
  mrcc_pkg::mem_wr_t               mem_wr;

  // handshake
  assign s1_adv      = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign accept      = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_write_q <= req_i.req_type;
      s1_addr_q  <= req_i.address;
      s1_wval_q  <= req_i.write_value;
      s1_shit_q  <= req_i.shared_hit;
      s1_sval_q  <= req_i.shared_value;
    end
  end

  // memory read for the fill, launched together with the request capture
  assign mem_rd.en   = accept;
  assign mem_rd.addr = req_i.address[mrcc_pkg::MEM_IDX_W-1:0];

  mrcc_backing_mem u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_i   (mem_rd),
    .wr_i   (mem_wr),
    .fill_o (fill)
  );

  // line lookup
  assign idx         = s1_addr_q[mrcc_pkg::LINE_IDX_W-1:0];
  assign cur_st      = states_q[idx];
  assign cur_tag     = tags_q[idx];
  assign cur_val     = values_q[idx];
  assign holds       = (cur_st != mrcc_pkg::ST_INVALID) && (cur_tag == s1_addr_q);
  assign evict_dirty = (cur_st == mrcc_pkg::ST_MODIFIED) && (cur_tag != s1_addr_q);

  // request decision
  always_comb begin
    cmd_d   = mrcc_pkg::CMD_NONE;
    baddr_d = '0;
    bdata_d = '0;
    val_d   = cur_val;
    st_d    = cur_st;
    wb_d    = 1'b0;
    upd_d   = 1'b0;
    if (s1_write_q) begin
      cmd_d   = mrcc_pkg::CMD_WRITE;
      baddr_d = s1_addr_q;
      bdata_d = s1_wval_q;
      val_d   = s1_wval_q;
      st_d    = mrcc_pkg::ST_MODIFIED;
      wb_d    = evict_dirty;
      upd_d   = 1'b1;
    end else if (!holds) begin
      cmd_d   = mrcc_pkg::CMD_READ;
      baddr_d = s1_addr_q;
      bdata_d = '1;
      wb_d    = evict_dirty;
      upd_d   = 1'b1;
      if (s1_shit_q) begin
        val_d = s1_sval_q;
        st_d  = mrcc_pkg::ST_SHARED;
      end else begin
        val_d = fill;
        st_d  = mrcc_pkg::ST_EXCLUSIVE;
      end
    end
  end

  // write-back of the evicted modified line
  assign mem_wr.en   = s1_adv && wb_d;
  assign mem_wr.addr = cur_tag[mrcc_pkg::MEM_IDX_W-1:0];
  assign mem_wr.data = cur_val;

  // line state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mrcc_pkg::LINES; i++) begin
        states_q[i] <= mrcc_pkg::ST_INVALID;
      end
    end else if (s1_adv && upd_d) begin
      states_q[idx] <= st_d;
    end
  end

  // line tag and data update
  always_ff @(posedge clk_i) begin
    if (s1_adv && upd_d) begin
      tags_q[idx]   <= s1_addr_q;
      values_q[idx] <= val_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_cmd_q    <= cmd_d;
      out_baddr_q  <= baddr_d;
      out_bdata_q  <= bdata_d;
      out_ldata_q  <= val_d;
      out_lstate_q <= st_d;
      out_wb_q     <= wb_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.bus_cmd     = out_cmd_q;
  assign rsp_o.bus_address = out_baddr_q;
  assign rsp_o.bcast_data  = out_bdata_q;
  assign rsp_o.line_data   = out_ldata_q;
  assign rsp_o.line_state  = out_lstate_q;
  assign rsp_o.wrote_back  = out_wb_q;

endmodule

// ===== tb/sv/mesi_requester_cache_controller_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mesi_requester_cache_controller_core_tb
// Self-checking bench for the MESI requester cache controller. A directed
// table walks fills, hits, upgrades and dirty evictions, then random
// requests over a few hot lines run through phases of idle and stall on
// both channels, including a long result hold-off. Each result is checked against
// a cache and memory model kept in the bench, or against the result of a typed row.
// ----------------------------------------------------------------------------
module mesi_requester_cache_controller_core_tb;
  import mrcc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RAND_PER_PH  = 300;
  localparam int unsigned PRESSURE_CNT = 60;
  localparam int unsigned SETTLE_CYC   = 8;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned DIR_CNT      = 21;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef struct packed {
    logic                     req_type;
    logic [ADDR_W-1:0]        address;
    logic signed [DATA_W-1:0] write_value;
    logic                     shared_hit;
    logic signed [DATA_W-1:0] shared_value;
  } cache_req_t;

  typedef struct packed {
    bus_cmd_e                 cmd;
    logic [ADDR_W-1:0]        bus_address;
    logic signed [DATA_W-1:0] bcast_data;
    logic signed [DATA_W-1:0] line_data;
    line_state_e              line_state;
    logic                     wrote_back;
  } cache_rsp_t;

  typedef struct packed {
    logic       typed;
    cache_req_t req;
    cache_rsp_t rsp;
  } dir_row_t;

  // directed requests; typed rows carry a hand-computed result
  localparam dir_row_t DIR_ROWS [DIR_CNT] = '{
    // cold read miss, filled from memory
    '{1'b1, '{REQ_READ,  8'h00, 8'sh00, 1'b0, 8'sh00},
            '{CMD_READ,  8'h00, 8'shFF, 8'sh00, ST_EXCLUSIVE, 1'b0}},
    // read hit ignores the other cache
    '{1'b1, '{REQ_READ,  8'h00, 8'sh00, 1'b1, 8'sh55},
            '{CMD_NONE,  8'h00, 8'sh00, 8'sh00, ST_EXCLUSIVE, 1'b0}},
    // read miss answered by the other cache
    '{1'b1, '{REQ_READ,  8'hFF, 8'sh00, 1'b1, 8'sh80},
            '{CMD_READ,  8'hFF, 8'shFF, 8'sh80, ST_SHARED, 1'b0}},
    // shared line upgraded by a write
    '{1'b1, '{REQ_WRITE, 8'hFF, 8'sh7F, 1'b0, 8'sh00},
            '{CMD_WRITE, 8'hFF, 8'sh7F, 8'sh7F, ST_MODIFIED, 1'b0}},
    // write hit on a modified line, no write-back
    '{1'b1, '{REQ_WRITE, 8'hFF, 8'sh80, 1'b1, 8'sh7F},
            '{CMD_WRITE, 8'hFF, 8'sh80, 8'sh80, ST_MODIFIED, 1'b0}},
    // read evicts the dirty line
    '{1'b1, '{REQ_READ,  8'h0F, 8'sh00, 1'b0, 8'sh00},
            '{CMD_READ,  8'h0F, 8'shFF, 8'sh00, ST_EXCLUSIVE, 1'b1}},
    '{1'b0, '{REQ_READ,  8'hFF, 8'sh00, 1'b0, 8'sh00},
            '{CMD_NONE,  8'h00, 8'sh00, 8'sh00, ST_INVALID, 1'b0}},
    '{1'b0, '{REQ_WRITE, 8'h10, 8'sh5A, 1'b0, 8'sh00},
            '{CMD_NONE,  8'h00, 8'sh00, 8'sh00, ST_INVALID, 1'b0}},
    '{1'b0, '{REQ_READ,  8'h20, 8'sh00, 1'b0, 8'sh00},
            '{CMD_NONE,  8'h00, 8'sh00, 8'sh00, ST_INVALID, 1'b0}},
    '{1'b0, '{REQ_WRITE, 8'h30, 8'sh01, 1'b0, 8'sh00},
            '{CMD_NONE,  8'h00, 8'sh00, 8'sh00, ST_INVALID, 1'b0}},
    '{1'b0, '{REQ_WRITE, 8'h40, 8'sh02, 1'b1, 8'sh00},
            '{CMD_NONE,  8'h00, 8'sh00, 8'sh00, ST_INVALID, 1'b0}},
    '{1'b0, '{REQ_READ,  8'h30, 8'sh00, 1'b0, 8'sh00},
            '{CMD_NONE,  8'h00, 8'sh00, 8'sh00, ST_INVALID, 1'b0}},
    '{1'b0, '{REQ_READ,  8'h10, 8'sh00, 1'b1, 8'sh33},
            '{CMD_NONE,  8'h00, 8'sh00, 8'sh00, ST_INVALID, 1'b0}},
    '{1'b0, '{REQ_WRITE, 8'h10, 8'shA5, 1'b0, 8'sh00},
            '{CMD_NONE,  8'h00, 8'sh00, 8'sh00, ST_INVALID, 1'b0}},
    '{1'b0, '{REQ_READ,  8'h20, 8'sh00, 1'b1, 8'shFF},
            '{CMD_NONE,  8'h00, 8'sh00, 8'sh00, ST_INVALID, 1'b0}},
    '{1'b0, '{REQ_READ,  8'h7F, 8'sh00, 1'b1, 8'sh7F},
            '{CMD_NONE,  8'h00, 8'sh00, 8'sh00, ST_INVALID, 1'b0}},
    '{1'b0, '{REQ_WRITE, 8'h80, 8'sh00, 1'b0, 8'sh00},
            '{CMD_NONE,  8'h00, 8'sh00, 8'sh00, ST_INVALID, 1'b0}},
    '{1'b0, '{REQ_READ,  8'h80, 8'shFF, 1'b1, 8'sh11},
            '{CMD_NONE,  8'h00, 8'sh00, 8'sh00, ST_INVALID, 1'b0}},
    '{1'b0, '{REQ_WRITE, 8'h8F, 8'shFF, 1'b1, 8'shFF},
            '{CMD_NONE,  8'h00, 8'sh00, 8'sh00, ST_INVALID, 1'b0}},
    '{1'b0, '{REQ_READ,  8'h40, 8'sh00, 1'b0, 8'sh00},
            '{CMD_NONE,  8'h00, 8'sh00, 8'sh00, ST_INVALID, 1'b0}},
    '{1'b0, '{REQ_READ,  8'h10, 8'sh00, 1'b0, 8'sh00},
            '{CMD_NONE,  8'h00, 8'sh00, 8'sh00, ST_INVALID, 1'b0}}
  };

  logic clk_i;
  logic rst_ni;

  mrcc_req_if req_if ();
  mrcc_rsp_if rsp_if ();

  mesi_requester_cache_controller_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // cache and memory image kept by the bench
  line_state_e              line_st_q  [LINES];
  logic [ADDR_W-1:0]        line_tag_q [LINES];
  logic signed [DATA_W-1:0] line_val_q [LINES];
  logic signed [DATA_W-1:0] mem_q      [MEM_WORDS];

  cache_rsp_t  expected_rsp_q [$];
  int unsigned fail_cnt;
  int unsigned cycle_cnt;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned hold_trigger;

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // apply one request to the cache image and return its result
  function automatic cache_rsp_t cache_access(cache_req_t r);
    int unsigned idx;
    line_state_e st;
    logic        holds;
    logic        dirty_evict;
    cache_rsp_t  p;
    idx         = r.address % LINES;
    st          = line_st_q[idx];
    holds       = (st != ST_INVALID) && (line_tag_q[idx] == r.address);
    dirty_evict = (st == ST_MODIFIED) && (line_tag_q[idx] != r.address);
    p           = '0;
    p.cmd       = CMD_NONE;
    // old dirty byte goes to memory before any fill
    if (dirty_evict) begin
      mem_q[line_tag_q[idx] % MEM_WORDS] = line_val_q[idx];
      p.wrote_back = 1'b1;
    end
    if (r.req_type == REQ_WRITE) begin
      p.cmd           = CMD_WRITE;
      p.bus_address   = r.address;
      p.bcast_data    = r.write_value;
      line_st_q[idx]  = ST_MODIFIED;
      line_val_q[idx] = r.write_value;
      line_tag_q[idx] = r.address;
    end else if (!holds) begin
      p.cmd         = CMD_READ;
      p.bus_address = r.address;
      p.bcast_data  = -8'sd1;
      if (r.shared_hit) begin
        line_val_q[idx] = r.shared_value;
        line_st_q[idx]  = ST_SHARED;
      end else begin
        line_val_q[idx] = mem_q[r.address % MEM_WORDS];
        line_st_q[idx]  = ST_EXCLUSIVE;
      end
      line_tag_q[idx] = r.address;
    end
    p.line_data  = line_val_q[idx];
    p.line_state = line_st_q[idx];
    return p;
  endfunction

  // random request, mostly over a few hot lines so hits and evictions occur
  function automatic cache_req_t rand_request();
    cache_req_t  r;
    logic [3:0]  hot_tag;
    r.req_type = ($urandom_range(99) < 40) ? REQ_WRITE : REQ_READ;
    if ($urandom_range(99) < 65) begin
      case ($urandom_range(2))
        0:       hot_tag = 4'h0;
        1:       hot_tag = 4'h9;
        default: hot_tag = 4'hF;
      endcase
      r.address = {hot_tag, 2'b00, 2'($urandom_range(3))};
    end else begin
      r.address = 8'($urandom);
    end
    r.write_value  = 8'($urandom);
    r.shared_hit   = 1'($urandom_range(1));
    r.shared_value = 8'($urandom);
    return r;
  endfunction

  // offer one item, wait for acceptance, record its result, maybe go idle
  task automatic drive_item(cache_req_t r, logic use_typed, cache_rsp_t typed_rsp);
    cache_rsp_t pred;
    req_if.valid        <= 1'b1;
    req_if.req_type     <= r.req_type;
    req_if.address      <= r.address;
    req_if.write_value  <= r.write_value;
    req_if.shared_hit   <= r.shared_hit;
    req_if.shared_value <= r.shared_value;
    do @(posedge clk_i); while (!req_if.ready);
    pred = cache_access(r);
    expected_rsp_q.push_back(use_typed ? typed_rsp : pred);
    if ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(int unsigned n, int unsigned idle_pct, int unsigned stall_pct);
    tx_idle_pct  = idle_pct;
    rx_stall_pct = stall_pct;
    repeat (n) drive_item(rand_request(), 1'b0, '0);
    req_if.valid <= 1'b0;
    wait_drained();
  endtask

  // result side ready, with random stalls and long hold-offs
  initial begin : result_ready_gen
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left    = 0;
    hold_seen    = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_trigger != hold_seen) begin
        hold_seen = hold_trigger;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin : result_check
    cache_rsp_t exp_rsp;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsp_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("[%0t] result with no request pending: cmd=%0d addr=%02h", $realtime,
                   rsp_if.bus_cmd, rsp_if.bus_address);
      end else begin
        exp_rsp = expected_rsp_q.pop_front();
        if (rsp_if.bus_cmd !== exp_rsp.cmd || rsp_if.bus_address !== exp_rsp.bus_address ||
            rsp_if.bcast_data !== exp_rsp.bcast_data || rsp_if.line_data !== exp_rsp.line_data ||
            rsp_if.line_state !== exp_rsp.line_state ||
            rsp_if.wrote_back !== exp_rsp.wrote_back) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS) begin
            $display("[%0t] mismatch exp cmd=%0d addr=%02h bdata=%0d line=%0d st=%0d wb=%0b",
                     $realtime, exp_rsp.cmd, exp_rsp.bus_address, exp_rsp.bcast_data,
                     exp_rsp.line_data, exp_rsp.line_state, exp_rsp.wrote_back);
            $display("[%0t]          got cmd=%0d addr=%02h bdata=%0d line=%0d st=%0d wb=%0b",
                     $realtime, rsp_if.bus_cmd, rsp_if.bus_address, rsp_if.bcast_data,
                     rsp_if.line_data, rsp_if.line_state, rsp_if.wrote_back);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // main sequence
  initial begin
    fail_cnt     = 0;
    cycle_cnt    = 0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_trigger = 0;
    for (int i = 0; i < LINES; i++) begin
      line_st_q[i]  = ST_INVALID;
      line_tag_q[i] = '0;
      line_val_q[i] = '0;
    end
    for (int i = 0; i < MEM_WORDS; i++) mem_q[i] = '0;

    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.req_type     <= REQ_READ;
    req_if.address      <= '0;
    req_if.write_value  <= '0;
    req_if.shared_hit   <= 1'b0;
    req_if.shared_value <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < DIR_CNT; i++)
      drive_item(DIR_ROWS[i].req, DIR_ROWS[i].typed, DIR_ROWS[i].rsp);
    req_if.valid <= 1'b0;
    wait_drained();

    // random phases: free running, sender idle, receiver stall, both
    run_random(RAND_PER_PH, 0, 0);
    run_random(RAND_PER_PH, 47, 0);
    run_random(RAND_PER_PH, 0, 47);
    run_random(RAND_PER_PH, 25, 25);

    // long result hold-off while requests keep coming, so the input backs up
    hold_trigger++;
    run_random(PRESSURE_CNT, 0, 0);

    repeat (SETTLE_CYC) @(posedge clk_i);
    if (expected_rsp_q.size() != 0) fail_cnt++;
    if (fail_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
